// ----- hdl/upl_pkg.sv -----
// ----------------------------------------------------------------------------
// upl_pkg: shared types for the unordered pair list
// Status codes and the command and status groups between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package upl_pkg;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    scan;
    logic    commit;
    logic    set_status;
    status_t code;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic cnt_full;
    logic cnt_zero;
    logic cmp_live;
    logic cmp_hit;
    logic cmp_last;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage

// ----- hdl/upl_if.sv -----
// ----------------------------------------------------------------------------
// upl_if: request and response channels
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface upl_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;

  modport source (output valid, output mode, output first_value, output second_value,
                  input ready);
  modport sink   (input valid, input mode, input first_value, input second_value,
                  output ready);
endinterface

interface upl_rsp_if;
  logic               valid;
  logic               ready;
  upl_pkg::status_t   status;
  logic [4:0]         count;
  logic               is_empty;

  modport source (output valid, output status, output count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input count, input is_empty,
                  output ready);
endinterface

// ----- hdl/upl_ctrl.sv -----
// ----------------------------------------------------------------------------
// upl_ctrl: request sequencer
// Runs the clearing pass, takes one request, checks the count, steers the
// entry scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module upl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  upl_pkg::stat_t stat,
  output upl_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.code   = upl_pkg::ST_DONE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.mode == upl_pkg::MODE_INSERT && stat.cnt_full) begin
          cmd.set_status = 1'b1;
          cmd.code       = upl_pkg::ST_FULL;
          state_next     = S_FINISH;
        end else if (stat.mode == upl_pkg::MODE_DELETE && stat.cnt_zero) begin
          cmd.set_status = 1'b1;
          cmd.code       = upl_pkg::ST_EMPTY;
          state_next     = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.cmp_live && stat.cmp_hit) begin
          cmd.commit = 1'b1;
          state_next = S_FINISH;
        end else if (stat.cmp_live && stat.cmp_last) begin
          cmd.set_status = 1'b1;
          cmd.code       = (stat.mode == upl_pkg::MODE_DELETE) ? upl_pkg::ST_NOT_FOUND
                                                               : upl_pkg::ST_FULL;
          state_next     = S_FINISH;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ----- hdl/upl_dp.sv -----
// ----------------------------------------------------------------------------
// upl_dp: pair store datapath
// Entry and valid memories with registered reads, scan address pipeline,
// pair compare, stored count and the output register.
// ----------------------------------------------------------------------------
module upl_dp #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  upl_pkg::cmd_t      cmd,
  output upl_pkg::stat_t     stat,
  input  logic               in_mode,
  input  logic signed [31:0] in_first,
  input  logic signed [31:0] in_second,
  output logic               out_valid,
  input  logic               out_ready,
  output upl_pkg::status_t   out_status,
  output logic [4:0]         out_count,
  output logic               out_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic        req_mode;
  logic [31:0] req_a;
  logic [31:0] req_b;

  logic [31:0] mem_first  [CAPACITY];
  logic [31:0] mem_second [CAPACITY];
  logic        mem_valid  [CAPACITY];
  logic [31:0] rd_first;
  logic [31:0] rd_second;
  logic        rd_valid;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cmp_addr;
  logic [AW-1:0] clr_addr;
  logic          issue_left;
  logic          cmp_live;
  logic          cmp_last;
  logic [CW-1:0] cnt;
  upl_pkg::status_t pend_status;

  logic          read_en;
  logic          vw_en;
  logic [AW-1:0] vw_addr;
  logic          vw_data;
  logic          cmp_hit;

  assign read_en = cmd.scan && issue_left;
  assign vw_en   = cmd.clear || cmd.commit;
  assign vw_addr = cmd.clear ? clr_addr : cmp_addr;
  assign vw_data = !cmd.clear && (req_mode == upl_pkg::MODE_INSERT);
  assign cmp_hit = (req_mode == upl_pkg::MODE_DELETE)
                 ? (rd_valid && rd_first == req_a && rd_second == req_b)
                 : !rd_valid;

  always_comb begin
    stat          = '0;
    stat.mode     = req_mode;
    stat.cnt_full = (cnt >= CAP_C);
    stat.cnt_zero = (cnt == '0);
    stat.cmp_live = cmp_live;
    stat.cmp_hit  = cmp_hit;
    stat.cmp_last = cmp_last;
    stat.clr_last = (clr_addr == LAST);
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= in_mode;
      req_a    <= in_first;
      req_b    <= in_second;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && req_mode == upl_pkg::MODE_INSERT) begin
      mem_first[cmp_addr]  <= req_a;
      mem_second[cmp_addr] <= req_b;
    end
    if (read_en) begin
      rd_first  <= mem_first[rd_addr];
      rd_second <= mem_second[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      mem_valid[vw_addr] <= vw_data;
    end
    if (read_en) begin
      rd_valid <= mem_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr     <= '0;
      cmp_addr    <= '0;
      clr_addr    <= '0;
      issue_left  <= 1'b0;
      cmp_live    <= 1'b0;
      cmp_last    <= 1'b0;
      cnt         <= '0;
      pend_status <= upl_pkg::ST_DONE;
      out_valid   <= 1'b0;
      out_status  <= upl_pkg::ST_DONE;
      out_count   <= '0;
      out_empty   <= 1'b1;
    end else begin
      if (cmd.capture) begin
        rd_addr    <= '0;
        issue_left <= 1'b1;
        cmp_live   <= 1'b0;
      end else begin
        cmp_live <= read_en;
        if (read_en) begin
          cmp_addr <= rd_addr;
          cmp_last <= (rd_addr == LAST);
          rd_addr  <= rd_addr + AW'(1);
          if (rd_addr == LAST) begin
            issue_left <= 1'b0;
          end
        end
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.commit) begin
        cnt         <= (req_mode == upl_pkg::MODE_DELETE) ? cnt - CW'(1) : cnt + CW'(1);
        pend_status <= upl_pkg::ST_DONE;
      end else if (cmd.set_status) begin
        pend_status <= cmd.code;
      end
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_count  <= 5'(cnt);
        out_empty  <= (cnt == '0);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/unordered_pair_list.sv -----
// ----------------------------------------------------------------------------
// unordered_pair_list: fixed-capacity store of value pairs
// Inserts a pair into a free slot or deletes one entry matching both fields,
// and reports a status, the new count and an empty flag for each request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Item
//  req      in         mode, first_value, second_value
//  rsp      out        status, count, is_empty
//
//  A refused insert (store full) or a delete on an empty store goes from the
//  count check straight to the result. Other requests scan the entries one per
//  cycle through the registered memory read, up to all CAPACITY entries.
//  After reset a clearing pass over all CAPACITY entries resets the valid marks,
//  with req.ready low. A request is taken only once the previous one is finished;
//  a stalled result holds in the output register.
// ----------------------------------------------------------------------------
module unordered_pair_list #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  upl_req_if.sink   req,
  upl_rsp_if.source rsp
);

  upl_pkg::cmd_t  cmd;
  upl_pkg::stat_t stat;

  upl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  upl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (req.mode),
    .in_first   (req.first_value),
    .in_second  (req.second_value),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_count  (rsp.count),
    .out_empty  (rsp.is_empty)
  );

endmodule

// ----- dv/tb_unordered_pair_list.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unordered_pair_list: self-checking testbench for the unordered pair list
// A queue of insert and delete requests feeds a clocked driver. The driver
// updates a shadow store on every accepted request, and a clocked monitor
// checks each response against the oldest predicted one. Both sides pause
// at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_unordered_pair_list;

  localparam int CAPACITY       = 16;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;

  typedef struct {
    logic        mode;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } pair_req_t;

  typedef struct {
    upl_pkg::status_t status;
    logic [4:0]       count;
    logic             is_empty;
  } pair_rsp_t;

  typedef struct {
    logic [31:0] first_value;
    logic [31:0] second_value;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  upl_req_if req ();
  upl_rsp_if rsp ();

  unordered_pair_list #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pair_req_t   pending_reqs[$];
  pair_rsp_t   expected_rsps[$];
  pair_t       stored_pairs[$];

  logic [31:0] slot_first [CAPACITY];
  logic [31:0] slot_second[CAPACITY];
  bit          slot_live  [CAPACITY];
  int          live_count;

  bit          req_active;
  bit          send_quiet;
  bit          recv_quiet;
  int          send_wait;
  int          recv_wait;
  int          idle_cycles;
  int unsigned error_count;

  function automatic pair_rsp_t apply_request(pair_req_t r);
    pair_rsp_t result;
    int        slot;
    slot = -1;
    if (r.mode == upl_pkg::MODE_INSERT) begin
      if (live_count < CAPACITY) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !slot_live[i]) slot = i;
        end
      end
      if (slot < 0) begin
        result.status = upl_pkg::ST_FULL;
      end else begin
        slot_first[slot]  = r.first_value;
        slot_second[slot] = r.second_value;
        slot_live[slot]   = 1'b1;
        live_count++;
        result.status = upl_pkg::ST_DONE;
      end
    end else if (live_count == 0) begin
      result.status = upl_pkg::ST_EMPTY;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot < 0 && slot_live[i] && slot_first[i] == r.first_value &&
            slot_second[i] == r.second_value) slot = i;
      end
      if (slot < 0) begin
        result.status = upl_pkg::ST_NOT_FOUND;
      end else begin
        slot_live[slot] = 1'b0;
        live_count--;
        result.status = upl_pkg::ST_DONE;
      end
    end
    result.count    = 5'(live_count);
    result.is_empty = (live_count == 0);
    return result;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] pool[8];
    int          kind;
    pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    if (kind < 7) return pool[$urandom_range(0, 7)];
    if (kind < 9) return 32'($urandom_range(0, 15));
    return -32'($urandom_range(1, 16));
  endfunction

  // Keeps a multiset of the stored pairs so that deletes can aim at real entries.
  function automatic void queue_request(logic mode, logic [31:0] a, logic [31:0] b);
    pair_req_t r;
    int        hit;
    r.mode         = mode;
    r.first_value  = a;
    r.second_value = b;
    pending_reqs.push_back(r);
    hit = -1;
    if (mode == upl_pkg::MODE_INSERT) begin
      if (stored_pairs.size() < CAPACITY) stored_pairs.push_back('{a, b});
    end else begin
      foreach (stored_pairs[i]) begin
        if (hit < 0 && stored_pairs[i].first_value == a &&
            stored_pairs[i].second_value == b) hit = i;
      end
      if (hit >= 0) stored_pairs.delete(hit);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_active = 1'b0;
      send_wait  = 0;
      req.valid <= 1'b0;
    end else begin
      if (req_active && req.ready) begin
        expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
        req_active = 1'b0;
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        send_wait = send_quiet ? 0 : $urandom_range(0, 18);
      end
      if (!req_active) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_reqs.size() > 0) begin
          req.mode         <= pending_reqs[0].mode;
          req.first_value  <= pending_reqs[0].first_value;
          req.second_value <= pending_reqs[0].second_value;
          req_active = 1'b1;
        end
      end
      req.valid <= req_active;
    end
  end

  always @(posedge clk) begin
    pair_rsp_t want;
    if (rst) begin
      recv_wait = 0;
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            error_count++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp.count);
            error_count++;
          end
          if (rsp.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp.is_empty);
            error_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 18);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_unordered_pair_list failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pair_t       p;
    logic [31:0] a;
    logic [31:0] b;
    int          kind;
    int          insert_bias;
    req.valid        = 1'b0;
    req.mode         = upl_pkg::MODE_INSERT;
    req.first_value  = '0;
    req.second_value = '0;
    rsp.ready        = 1'b0;
    idle_cycles      = 0;
    error_count      = 0;
    live_count       = 0;
    send_quiet       = 1'b0;
    recv_quiet       = 1'b0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;

    // Empty store, extreme values, deletes that match one field only, and
    // duplicate pairs, then a fill up to a refused insert.
    queue_request(upl_pkg::MODE_DELETE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(upl_pkg::MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(upl_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(upl_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_request(upl_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(upl_pkg::MODE_DELETE, 32'h8000_0000, 32'h8000_0000);
    queue_request(upl_pkg::MODE_DELETE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(upl_pkg::MODE_DELETE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(upl_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(upl_pkg::MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(upl_pkg::MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(upl_pkg::MODE_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY - 2; i++) begin
      queue_request(upl_pkg::MODE_INSERT, pick_value(), pick_value());
    end
    queue_request(upl_pkg::MODE_INSERT, 32'h1234_5678, 32'h9ABC_DEF0);
    queue_request(upl_pkg::MODE_DELETE, 32'h7FFF_FFFF, 32'h8000_0000);

    insert_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        kind = $urandom_range(0, 2);
        insert_bias = (kind == 0) ? 25 : (kind == 1) ? 50 : 80;
      end
      if ($urandom_range(0, 99) < insert_bias) begin
        queue_request(upl_pkg::MODE_INSERT, pick_value(), pick_value());
      end else begin
        kind = $urandom_range(0, 99);
        if (stored_pairs.size() > 0 && kind < 85) begin
          p = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
          a = p.first_value;
          b = p.second_value;
          if (kind >= 65) begin
            if ($urandom_range(0, 1)) a = a ^ (32'h1 << $urandom_range(0, 31));
            else b = b ^ (32'h1 << $urandom_range(0, 31));
          end
          queue_request(upl_pkg::MODE_DELETE, a, b);
        end else begin
          queue_request(upl_pkg::MODE_DELETE, pick_value(), pick_value());
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_reqs.size() > 0 || req_active || expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_unordered_pair_list passed");
    end else begin
      $display("tb_unordered_pair_list failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/upl_pkg.sv
hdl/upl_if.sv
hdl/upl_ctrl.sv
hdl/upl_dp.sv
hdl/unordered_pair_list.sv
dv/tb_unordered_pair_list.sv
